// ----- src/v3ln_pkg.sv -----
package v3ln_pkg;

    typedef struct packed {
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } t_in_beat;

    typedef struct packed {
        logic        [15:0] length_out;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               degenerate;
    } t_out_beat;

    localparam logic [31:0] MSL_RESET = 32'd16777;
    localparam logic signed [15:0] UNIT_NEG_ONE = -16'sd16384;
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS = 15;

endpackage

// ----- src/vector3_length_normalize_core.sv -----
// vector3 length and normalize core
// input: drive i_vec with i_start high for one cycle per vector; o_busy is
// always low, so a new vector may be given in every cycle.
// config: i_cfg_we with i_cfg_data writes the squared-length threshold; write
// only while no vector is in flight.
// output: o_result carries the length and unit vector for one cycle, marked
// by o_valid. the pipeline has a square stage, a sum stage, 16 root steps,
// a setup stage, 15 divide steps and an output register; throughput is one
// vector per cycle. the depth is set by the bit-per-stage square root and
// restoring divide pipelines, each stage resolving one result bit.
// reset clears all valid bits and loads the threshold with its default.
// the receiver cannot stall; results always leave in order.
module vector3_length_normalize_core
    import v3ln_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_beat  i_vec,
    input  logic      i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic      o_valid,
    output t_out_beat o_result
);

    localparam int NS = SQRT_STEPS;
    localparam int ND = DIV_STEPS;

    logic [31:0] r_msl;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msl <= MSL_RESET;
        end else if (i_cfg_we) begin
            r_msl <= i_cfg_data;
        end
    end

    assign o_busy = 1'b0;

    // stage 1: squares, kept 31 bits wide so that -32768 squared keeps its bit
    logic        r_v1;
    logic [30:0] r_sq [3];
    logic signed [15:0] r_c1 [3];
    logic signed [31:0] n_sq [3];
    assign n_sq[0] = i_vec.vec_x * i_vec.vec_x;
    assign n_sq[1] = i_vec.vec_y * i_vec.vec_y;
    assign n_sq[2] = i_vec.vec_z * i_vec.vec_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_start;
    end
    always_ff @(posedge i_clk) begin
        r_sq[0] <= n_sq[0][30:0];
        r_sq[1] <= n_sq[1][30:0];
        r_sq[2] <= n_sq[2][30:0];
        r_c1[0] <= i_vec.vec_x;
        r_c1[1] <= i_vec.vec_y;
        r_c1[2] <= i_vec.vec_z;
    end

    // stage 2: sum and threshold compare
    logic        r_v2;
    logic [31:0] r_sum2;
    logic        r_deg2;
    logic signed [15:0] r_c2 [3];
    logic [31:0] n_sum2;
    assign n_sum2 = 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        r_sum2  <= n_sum2;
        r_deg2  <= !(n_sum2 > r_msl);
        r_c2    <= r_c1;
    end

    // square root pipeline: one root bit per stage
    logic        r_sv [NS+1];
    logic [33:0] r_rem [NS+1];
    logic [15:0] r_root [NS+1];
    logic [31:0] r_sval [NS+1];
    logic [31:0] r_ssum [NS+1];
    logic        r_sdeg [NS+1];
    logic signed [15:0] r_sc [NS+1][3];

    always_comb begin
        r_sv[0]   = r_v2;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_sval[0] = r_sum2;
        r_ssum[0] = r_sum2;
        r_sdeg[0] = r_deg2;
        r_sc[0]   = r_c2;
    end

    for (genvar s = 0; s < NS; s++) begin : g_sqrt
        logic [33:0] n_rem;
        logic [33:0] n_trial;
        assign n_rem   = {r_rem[s][31:0], r_sval[s][31:30]};
        assign n_trial = {16'd0, r_root[s], 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[s+1] <= 1'b0;
            else          r_sv[s+1] <= r_sv[s];
        end
        always_ff @(posedge i_clk) begin
            if (n_rem >= n_trial) begin
                r_rem[s+1]  <= n_rem - n_trial;
                r_root[s+1] <= {r_root[s][14:0], 1'b1};
            end else begin
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= {r_root[s][14:0], 1'b0};
            end
            r_sval[s+1] <= {r_sval[s][29:0], 2'b00};
            r_ssum[s+1] <= r_ssum[s];
            r_sdeg[s+1] <= r_sdeg[s];
            r_sc[s+1]   <= r_sc[s];
        end
    end

    // divide setup: magnitudes, signs, degenerate length
    logic        r_dv0;
    logic [15:0] r_len;
    logic        r_deg;
    logic [15:0] r_dlen;
    logic [15:0] r_mag [3];
    logic        r_neg [3];
    logic        n_deg;
    assign n_deg = r_sdeg[NS] || (r_root[NS] == 16'd0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv0 <= 1'b0;
        else          r_dv0 <= r_sv[NS];
    end
    always_ff @(posedge i_clk) begin
        r_len  <= r_root[NS];
        r_deg  <= n_deg;
        r_dlen <= (r_ssum[NS][31:28] != 4'd0) ? 16'hFFFF : r_ssum[NS][27:12];
        for (int k = 0; k < 3; k++) begin
            r_neg[k] <= r_sc[NS][k][15];
            r_mag[k] <= r_sc[NS][k][15] ? 16'(-r_sc[NS][k]) : 16'(r_sc[NS][k]);
        end
    end

    // restoring divide: (mag << 14) / len, 15 quotient bits, |c| <= len
    logic        r_dvv [ND+1];
    logic [16:0] r_drem [ND+1][3];
    logic [14:0] r_q [ND+1][3];
    logic [15:0] r_dd [ND+1];
    logic        r_ddeg [ND+1];
    logic [15:0] r_ddl [ND+1];
    logic        r_dneg [ND+1][3];

    always_comb begin
        r_dvv[0]  = r_dv0;
        r_dd[0]   = r_len;
        r_ddeg[0] = r_deg;
        r_ddl[0]  = r_dlen;
        for (int k = 0; k < 3; k++) begin
            r_drem[0][k] = {1'b0, r_mag[k]};
            r_q[0][k]    = '0;
            r_dneg[0][k] = r_neg[k];
        end
    end

    for (genvar d = 0; d < ND; d++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dvv[d+1] <= 1'b0;
            else          r_dvv[d+1] <= r_dvv[d];
        end
        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic [16:0] n_rem;
            logic        n_ge;
            assign n_ge  = (d == 0) ? (r_drem[d][k] >= {1'b0, r_dd[d]}) : 1'b0;
            assign n_rem = (d == 0) ? r_drem[d][k] : {r_drem[d][k][15:0], 1'b0};
            always_ff @(posedge i_clk) begin
                if (n_rem >= {1'b0, r_dd[d]}) begin
                    r_drem[d+1][k] <= n_rem - {1'b0, r_dd[d]};
                    r_q[d+1][k]    <= {r_q[d][k][13:0], 1'b1};
                end else begin
                    r_drem[d+1][k] <= n_rem;
                    r_q[d+1][k]    <= {r_q[d][k][13:0], 1'b0};
                end
                r_dneg[d+1][k] <= r_dneg[d][k] ^ (n_ge & 1'b0);
            end
        end
        always_ff @(posedge i_clk) begin
            r_dd[d+1]   <= r_dd[d];
            r_ddeg[d+1] <= r_ddeg[d];
            r_ddl[d+1]  <= r_ddl[d];
        end
    end

    // output register: the first step yields the 2^14 bit, the rest the fraction
    logic [15:0] n_unit [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_unit[k] = r_dneg[ND][k] ? 16'(-{1'b0, r_q[ND][k]}) : {1'b0, r_q[ND][k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_dvv[ND];
    end
    always_ff @(posedge i_clk) begin
        if (r_ddeg[ND]) begin
            o_result.length_out <= r_ddl[ND];
            o_result.unit_x     <= '0;
            o_result.unit_y     <= UNIT_NEG_ONE;
            o_result.unit_z     <= '0;
            o_result.degenerate <= 1'b1;
        end else begin
            o_result.length_out <= r_dd[ND];
            o_result.unit_x     <= n_unit[0];
            o_result.unit_y     <= n_unit[1];
            o_result.unit_z     <= n_unit[2];
            o_result.degenerate <= 1'b0;
        end
    end

    // checks
    a_busy_low: assert property (@(posedge i_clk) o_busy == 1'b0)
        else $error("busy raised");
    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvv[ND] |=> o_valid) else $error("lost result");
    a_deg_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.degenerate |-> o_result.unit_y == UNIT_NEG_ONE)
        else $error("bad fallback");
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule
